@@ hw/rtl/ctt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, constants and codes of the context counter table.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int unsigned BUCKETS_DEF       = 4096;
  localparam int unsigned MAX_WAYS_DEF      = 16;
  localparam int unsigned TAG_BITS_DEF      = 8;
  localparam int unsigned ARRAY_CONTEXT_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF    = 16;

  // key = (ctx * 786433 + 196613) mod (2^36 - 1); 786433 = 2^19 + 2^18 + 1
  localparam int unsigned KEY_W    = 36;
  localparam logic [63:0] HASH_ADD = 64'd196613;
  localparam logic [KEY_W-1:0] HASH_MOD = 36'hF_FFFF_FFFF;

  localparam int unsigned FREQ_W  = 26;
  localparam int unsigned TOTAL_W = 28;
  localparam int unsigned ALPHA_W = 10;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned WAYSR_W = 5;

  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_HASHED_MODE = 2'd0;
  localparam logic [1:0] REG_ALPHA_SCALE = 2'd1;
  localparam logic [1:0] REG_COUNT_LIMIT = 2'd2;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd3;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] context_req;
    logic [1:0]  symbol;
  } in_req_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  freq_a;
    logic [FREQ_W-1:0]  freq_c;
    logic [FREQ_W-1:0]  freq_g;
    logic [FREQ_W-1:0]  freq_t;
    logic [TOTAL_W-1:0] freq_total;
  } out_rsp_t;

  typedef struct packed {
    logic               hashed_mode;
    logic [ALPHA_W-1:0] alpha_scale;
    logic [LIMIT_W-1:0] count_limit;
    logic [WAYSR_W-1:0] ways_in_use;
  } cfg_t;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic hash_p;
    logic hash_key;
    logic mod_step;
    logic mem_we;
    logic cnt_load;
    logic mul;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic hashed;
    logic kind;
    logic out_busy;
  } ctrl_status_t;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_KEY   = 9'b000001000,
    S_MOD   = 9'b000010000,
    S_READ  = 9'b000100000,
    S_EXEC  = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

endpackage
`default_nettype wire

@@ hw/rtl/ctt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ctt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

@@ hw/rtl/ctt_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_regs
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module ctt_regs import ctt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t       cfg_q;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hashed_mode <= 1'b1;
      cfg_q.alpha_scale <= ALPHA_W'(1);
      cfg_q.count_limit <= LIMIT_W'(65535);
      cfg_q.ways_in_use <= WAYSR_W'(8);
    end else if (wr) begin
      case (idx)
        REG_HASHED_MODE: cfg_q.hashed_mode <= pwdata[0];
        REG_ALPHA_SCALE: cfg_q.alpha_scale <= pwdata[ALPHA_W-1:0];
        REG_COUNT_LIMIT: cfg_q.count_limit <= pwdata[LIMIT_W-1:0];
        REG_WAYS_IN_USE: cfg_q.ways_in_use <= pwdata[WAYSR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HASHED_MODE: prdata = 32'(cfg_q.hashed_mode);
      REG_ALPHA_SCALE: prdata = 32'(cfg_q.alpha_scale);
      REG_COUNT_LIMIT: prdata = 32'(cfg_q.count_limit);
      REG_WAYS_IN_USE: prdata = 32'(cfg_q.ways_in_use);
      default:         prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/ctt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_ctrl
// Sequencer: clear pass, hashing, table read, update or frequency output.
// ----------------------------------------------------------------------------
module ctt_ctrl import ctt_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  ctrl_status_t      status_i,
  output ctrl_cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        if (status_i.clr_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.clr_step = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = status_i.hashed ? S_HASH : S_READ;
        end
      end
      S_HASH: begin
        cmd_o.hash_p = 1'b1;
        state_d = S_KEY;
      end
      S_KEY: begin
        cmd_o.hash_key = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        if (status_i.mod_done) begin
          state_d = S_READ;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        if (status_i.kind == KIND_UPDATE) begin
          cmd_o.mem_we = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.cnt_load = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/ctt_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_dpath
// Hash, bucket reduction, counter stores, update logic and frequency output.
// ----------------------------------------------------------------------------
module ctt_dpath import ctt_pkg::*; #(
  parameter int unsigned BUCKETS       = BUCKETS_DEF,
  parameter int unsigned MAX_WAYS      = MAX_WAYS_DEF,
  parameter int unsigned TAG_BITS      = TAG_BITS_DEF,
  parameter int unsigned ARRAY_CONTEXT = ARRAY_CONTEXT_DEF,
  parameter int unsigned COUNT_BITS    = COUNT_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  cfg_t              cfg_i,
  input  in_req_t           in_req_i,
  input  ctrl_cmd_t         cmd_i,
  output ctrl_status_t      status_o,
  input  wire logic         out_stall_i,
  output logic              out_valid_o,
  output out_rsp_t          out_data_o
);

  localparam int unsigned ARR_AW    = 2 * ARRAY_CONTEXT;
  localparam int unsigned ARR_DEPTH = 1 << ARR_AW;
  localparam int unsigned ARR_W     = 4 * COUNT_BITS;
  localparam int unsigned BKT_AW    = $clog2(BUCKETS);
  localparam int unsigned WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned ENT_W     = TAG_BITS + 8;
  localparam int unsigned BKT_W     = MAX_WAYS * ENT_W + WAY_W;
  localparam int unsigned CLR_DEPTH = (ARR_DEPTH > BUCKETS) ? ARR_DEPTH : BUCKETS;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);
  localparam bit          POW2      = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int unsigned MCNT_W    = 3;
  localparam int unsigned MOD_STEPS = 4;
  localparam int unsigned KH_W      = KEY_W / 2;
  localparam int unsigned REC_W     = 33;
  localparam int unsigned PP_W      = KH_W + REC_W;
  localparam int unsigned QS_W      = KEY_W + REC_W + 1;
  localparam int unsigned BW        = BKT_AW + 1;
  localparam int unsigned QB_W      = REC_W + BW;
  localparam logic [63:0] RECIP_FULL = (64'd1 << KEY_W) / 64'(BUCKETS);
  localparam logic [REC_W-1:0] RECIP = RECIP_FULL[REC_W-1:0];

  // ---------------- clear pass ----------------
  logic [CLR_W-1:0] clr_q;
  logic             clr_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clr_step) begin
      if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
        clr_done_q <= 1'b1;
      end else begin
        clr_q <= clr_q + CLR_W'(1);
      end
    end
  end

  // ---------------- request and hash ----------------
  in_req_t              req_q;
  logic [63:0]          p_q;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [KEY_W:0]       fold1;
  logic [KEY_W-1:0]     fold2;
  logic [PP_W-1:0]      pl_q, ph_q;
  logic [QS_W-1:0]      qsum;
  logic [REC_W-1:0]     q_q;
  logic [QB_W-1:0]      qb;
  logic [KEY_W-1:0]     r1_q;
  logic [BKT_AW-1:0]    rem_q;
  logic [MCNT_W-1:0]    mcnt_q;
  logic [BKT_AW-1:0]    bucket;
  logic [TAG_BITS-1:0]  tag;

  // 2^36 == 1 modulo the hash modulus, so the upper bits fold back in
  assign fold1 = {1'b0, p_q[KEY_W-1:0]} + (KEY_W+1)'(p_q[63:KEY_W]);
  assign fold2 = fold1[KEY_W-1:0] + KEY_W'(fold1[KEY_W]);
  assign key_d = (fold2 == HASH_MOD) ? '0 : fold2;

  // quotient from the reciprocal is low by at most one; one subtract fixes it
  assign qsum = (QS_W'(ph_q) << KH_W) + QS_W'(pl_q);
  assign qb   = QB_W'(q_q) * QB_W'(BUCKETS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q <= in_req_i;
    end
    if (cmd_i.hash_p) begin
      p_q <= req_q.context_req + (req_q.context_req << 18) + (req_q.context_req << 19)
             + HASH_ADD;
    end
    if (cmd_i.hash_key) begin
      key_q  <= key_d;
      mcnt_q <= '0;
    end else if (cmd_i.mod_step) begin
      case (mcnt_q)
        MCNT_W'(0): begin
          pl_q <= PP_W'(key_q[KH_W-1:0]) * PP_W'(RECIP);
          ph_q <= PP_W'(key_q[KEY_W-1:KH_W]) * PP_W'(RECIP);
        end
        MCNT_W'(1): q_q  <= qsum[KEY_W +: REC_W];
        MCNT_W'(2): r1_q <= key_q - qb[KEY_W-1:0];
        default: begin
          rem_q <= (r1_q >= KEY_W'(BUCKETS)) ? BKT_AW'(r1_q - KEY_W'(BUCKETS))
                                             : BKT_AW'(r1_q);
        end
      endcase
      mcnt_q <= mcnt_q + MCNT_W'(1);
    end
  end

  assign bucket = POW2 ? key_q[BKT_AW-1:0] : rem_q;
  assign tag    = key_q[TAG_BITS-1:0];

  // ---------------- stores ----------------
  logic              arr_we, bkt_we;
  logic [ARR_AW-1:0] arr_addr;
  logic [BKT_AW-1:0] bkt_addr;
  logic [ARR_W-1:0]  arr_rd, arr_wd;
  logic [BKT_W-1:0]  bkt_rd, bkt_wd;
  logic [ARR_W-1:0]  arr_upd;
  logic [BKT_W-1:0]  bkt_upd;

  always_comb begin
    if (!clr_done_q) begin
      arr_we   = cmd_i.clr_step && ({1'b0, clr_q} < (CLR_W+1)'(ARR_DEPTH));
      bkt_we   = cmd_i.clr_step && ({1'b0, clr_q} < (CLR_W+1)'(BUCKETS));
      arr_addr = clr_q[ARR_AW-1:0];
      bkt_addr = clr_q[BKT_AW-1:0];
      arr_wd   = '0;
      bkt_wd   = '0;
    end else begin
      arr_we   = cmd_i.mem_we && !cfg_i.hashed_mode;
      bkt_we   = cmd_i.mem_we && cfg_i.hashed_mode;
      arr_addr = req_q.context_req[ARR_AW-1:0];
      bkt_addr = bucket;
      arr_wd   = arr_upd;
      bkt_wd   = bkt_upd;
    end
  end

  ctt_ram #(.WIDTH(ARR_W), .DEPTH(ARR_DEPTH)) u_arr_ram (
    .clk_i   (clk_i),
    .we_i    (arr_we),
    .addr_i  (arr_addr),
    .wdata_i (arr_wd),
    .rdata_o (arr_rd)
  );

  ctt_ram #(.WIDTH(BKT_W), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .addr_i  (bkt_addr),
    .wdata_i (bkt_wd),
    .rdata_o (bkt_rd)
  );

  // ---------------- array-mode update ----------------
  logic [COUNT_BITS-1:0] acnt [4];
  logic [COUNT_BITS-1:0] anew;
  logic                  ahalve;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acnt[i] = arr_rd[i*COUNT_BITS +: COUNT_BITS];
    end
    anew   = acnt[req_q.symbol] + COUNT_BITS'(1);
    ahalve = (32'(anew) == 32'(cfg_i.count_limit));
    for (int i = 0; i < 4; i++) begin
      arr_upd[i*COUNT_BITS +: COUNT_BITS] =
        (2'(i) == req_q.symbol) ? (ahalve ? (anew >> 1) : anew)
                                : (ahalve ? (acnt[i] >> 1) : acnt[i]);
    end
  end

  // ---------------- hash-mode search and update ----------------
  logic [6:0]          wcfg, w, wm1;
  logic [WAY_W-1:0]    newest, pos, nx_idx;
  logic [6:0]          nx;
  logic [ENT_W-1:0]    ent [MAX_WAYS];
  logic [MAX_WAYS-1:0] match;
  logic                lo_hit, hi_hit, up_hit;
  logic [7:0]          lo_cnt, hi_cnt, up_cnt, lk_cnt, up_new;
  logic [WAY_W-1:0]    up_idx;
  logic [1:0]          cur;
  logic [ENT_W-1:0]    e;

  assign wcfg   = 7'(cfg_i.ways_in_use);
  assign w      = (wcfg == 7'd0) ? 7'd1 : ((wcfg > 7'(MAX_WAYS)) ? 7'(MAX_WAYS) : wcfg);
  assign wm1    = w - 7'd1;
  assign newest = bkt_rd[BKT_W-1 -: WAY_W];
  assign pos    = (7'(newest) >= w) ? wm1[WAY_W-1:0] : newest;
  assign nx     = (7'(newest) + 7'd1 >= w) ? 7'd0 : 7'(newest) + 7'd1;
  assign nx_idx = nx[WAY_W-1:0];

  always_comb begin
    lo_hit = 1'b0; hi_hit = 1'b0; up_hit = 1'b0;
    lo_cnt = '0;   hi_cnt = '0;   up_cnt = '0;
    up_idx = '0;
    for (int n = 0; n < MAX_WAYS; n++) begin
      ent[n]   = bkt_rd[n*ENT_W +: ENT_W];
      match[n] = (7'(n) < w) && (ent[n][ENT_W-1 -: TAG_BITS] == tag);
    end
    // lookup: newest down to 0, then the top down past newest
    for (int n = 0; n < MAX_WAYS; n++) begin
      if (match[n] && (7'(n) <= 7'(pos))) begin
        lo_hit = 1'b1;
        lo_cnt = ent[n][7:0];
      end
      if (match[n] && (7'(n) > 7'(pos))) begin
        hi_hit = 1'b1;
        hi_cnt = ent[n][7:0];
      end
    end
    // update: lowest matching way
    for (int n = MAX_WAYS - 1; n >= 0; n--) begin
      if (match[n]) begin
        up_hit = 1'b1;
        up_cnt = ent[n][7:0];
        up_idx = WAY_W'(n);
      end
    end
  end

  assign lk_cnt = lo_hit ? lo_cnt : hi_cnt;
  assign cur    = up_cnt[2*req_q.symbol +: 2];

  always_comb begin
    up_new = up_cnt;
    for (int s = 0; s < 4; s++) begin
      if (cur == 2'd3) begin
        if (2'(s) != req_q.symbol) begin
          up_new[2*s +: 2] = up_cnt[2*s +: 2] >> 1;
        end
      end else if (2'(s) == req_q.symbol) begin
        up_new[2*s +: 2] = cur + 2'd1;
      end
    end
    for (int n = 0; n < MAX_WAYS; n++) begin
      e = ent[n];
      if (up_hit && (up_idx == WAY_W'(n))) begin
        e[7:0] = up_new;
      end
      if (!up_hit && (nx_idx == WAY_W'(n))) begin
        e = {tag, 8'd1 << (2 * req_q.symbol)};
      end
      bkt_upd[n*ENT_W +: ENT_W] = e;
    end
    bkt_upd[BKT_W-1 -: WAY_W] = up_hit ? newest : nx_idx;
  end

  // ---------------- frequencies ----------------
  logic [COUNT_BITS-1:0] c_q [4];
  logic [FREQ_W-1:0]     f_q [4];
  logic [41:0]           prod [4];
  out_rsp_t              out_q;
  logic                  out_valid_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = 42'(cfg_i.alpha_scale) * 42'(c_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_load) begin
      for (int i = 0; i < 4; i++) begin
        if (cfg_i.hashed_mode) begin
          c_q[i] <= (lo_hit || hi_hit) ? COUNT_BITS'(lk_cnt[2*i +: 2]) : '0;
        end else begin
          c_q[i] <= acnt[i];
        end
      end
    end
    if (cmd_i.mul) begin
      for (int i = 0; i < 4; i++) begin
        f_q[i] <= prod[i][FREQ_W-1:0] + FREQ_W'(1);
      end
    end
    if (cmd_i.emit) begin
      out_q.freq_a     <= f_q[0];
      out_q.freq_c     <= f_q[1];
      out_q.freq_g     <= f_q[2];
      out_q.freq_t     <= f_q[3];
      out_q.freq_total <= TOTAL_W'(f_q[0]) + TOTAL_W'(f_q[1])
                        + TOTAL_W'(f_q[2]) + TOTAL_W'(f_q[3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.clr_done = clr_done_q;
  assign status_o.mod_done = POW2 ? 1'b1 : (mcnt_q == MCNT_W'(MOD_STEPS));
  assign status_o.hashed   = cfg_i.hashed_mode;
  assign status_o.kind     = req_q.kind;
  assign status_o.out_busy = out_valid_q && out_stall_i;

endmodule
`default_nettype wire

@@ hw/rtl/context_counter_table_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// context_counter_table_core
// Per-context symbol counters, direct array or hashed bucket ring.
// ----------------------------------------------------------------------------
// Array update: load, read, write back. Array lookup: load, read, counter
// load, multiply, emit (held while an output is stalled). Hashed mode adds
// hash and key steps, plus reciprocal remainder steps if BUCKETS is not a
// power of two. One request at a time; one table read-modify-write per request.
// Reset: a clearing pass over max(4^ARRAY_CONTEXT, BUCKETS) addresses (65536
// by default) zeroes both stores; requests are stalled until it ends.
module context_counter_table_core import ctt_pkg::*; #(
  parameter int unsigned BUCKETS       = BUCKETS_DEF,
  parameter int unsigned MAX_WAYS      = MAX_WAYS_DEF,
  parameter int unsigned TAG_BITS      = TAG_BITS_DEF,
  parameter int unsigned ARRAY_CONTEXT = ARRAY_CONTEXT_DEF,
  parameter int unsigned COUNT_BITS    = COUNT_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  in_req_t                in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_rsp_t               out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t         cfg;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  ctt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ctt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ctt_dpath #(
    .BUCKETS       (BUCKETS),
    .MAX_WAYS      (MAX_WAYS),
    .TAG_BITS      (TAG_BITS),
    .ARRAY_CONTEXT (ARRAY_CONTEXT),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_req_i    (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_no_req_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> status.clr_done)
    else $error("request accepted before clearing pass finished");

  a_emit_not_over_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_valid_o && out_stall_i))
    else $error("result overwrote a pending output");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("not busy after accepting a request");
`endif

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives lookups and updates into the context counter table in both modes,
// with the registers swept between phases. A local copy of the counter
// stores predicts each lookup's frequencies; a scoreboard checks them in order.
// ----------------------------------------------------------------------------
module tb_top
  import ctt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NB        = 4096;
  localparam int unsigned NWAYS     = 16;
  localparam int unsigned CTX_N     = 65536;
  localparam int unsigned IDLE_HOLD = 64;
  localparam int unsigned WD_LIMIT  = 200000;

  // predictor state
  logic [15:0] cnt_arr [CTX_N][4];
  logic [7:0]  way_tag [NB][NWAYS];
  logic [7:0]  way_cnt [NB][NWAYS];
  logic [3:0]  newest  [NB];
  cfg_t        cfg;

  class freq_scoreboard;
    out_rsp_t pending[$];
    int       errors;

    function void note_request(out_rsp_t exp_rsp);
      pending.push_back(exp_rsp);
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t e;
      if (pending.size() == 0) begin
        report("result with no request waiting");
        return;
      end
      e = pending.pop_front();
      if (got.freq_a !== e.freq_a) report($sformatf("freq_a %0d exp %0d", got.freq_a, e.freq_a));
      if (got.freq_c !== e.freq_c) report($sformatf("freq_c %0d exp %0d", got.freq_c, e.freq_c));
      if (got.freq_g !== e.freq_g) report($sformatf("freq_g %0d exp %0d", got.freq_g, e.freq_g));
      if (got.freq_t !== e.freq_t) report($sformatf("freq_t %0d exp %0d", got.freq_t, e.freq_t));
      if (got.freq_total !== e.freq_total)
        report($sformatf("freq_total %0d exp %0d", got.freq_total, e.freq_total));
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_data_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  freq_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned results_seen = 0;
  int unsigned out_wait = 0;

  always #4 clk_i = ~clk_i;

  context_counter_table_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  function automatic out_rsp_t freq_of(logic [15:0] c0, logic [15:0] c1,
                                       logic [15:0] c2, logic [15:0] c3);
    out_rsp_t r;
    logic [63:0] f0, f1, f2, f3;
    f0 = (64'd1 + cfg.alpha_scale * c0) & 64'h3FF_FFFF;
    f1 = (64'd1 + cfg.alpha_scale * c1) & 64'h3FF_FFFF;
    f2 = (64'd1 + cfg.alpha_scale * c2) & 64'h3FF_FFFF;
    f3 = (64'd1 + cfg.alpha_scale * c3) & 64'h3FF_FFFF;
    r.freq_a = f0[25:0];
    r.freq_c = f1[25:0];
    r.freq_g = f2[25:0];
    r.freq_t = f3[25:0];
    r.freq_total = 28'(f0 + f1 + f2 + f3);
    return r;
  endfunction

  function automatic int unsigned ways_eff();
    if (cfg.ways_in_use == 0) return 1;
    if (cfg.ways_in_use > NWAYS) return NWAYS;
    return cfg.ways_in_use;
  endfunction

  // returns 1 and the expected result when the request is a lookup
  function automatic bit predict_counts(in_req_t rq, output out_rsp_t rsp);
    logic [63:0] key;
    int unsigned bkt, w, pos, n, k, ix;
    logic [7:0] tg, v;
    logic [1:0] cur;
    logic [15:0] nv;
    rsp = '0;
    if (cfg.hashed_mode) begin
      key = (rq.context_req * 64'd786433 + 64'd196613) % 64'd68719476735;
      bkt = key % NB;
      tg  = key[7:0];
      w   = ways_eff();
      if (rq.kind == KIND_UPDATE) begin
        for (n = 0; n < w; n++) begin
          if (way_tag[bkt][n] == tg) begin
            v = way_cnt[bkt][n];
            cur = v[2*rq.symbol +: 2];
            if (cur == 2'd3) begin
              for (k = 0; k < 4; k++)
                if (k != rq.symbol) v[2*k +: 2] = v[2*k +: 2] >> 1;
            end else begin
              v[2*rq.symbol +: 2] = cur + 2'd1;
            end
            way_cnt[bkt][n] = v;
            return 0;
          end
        end
        n = newest[bkt] + 1;
        if (n >= w) n = 0;
        newest[bkt] = n[3:0];
        way_tag[bkt][n] = tg;
        way_cnt[bkt][n] = 8'd1 << (2 * rq.symbol);
        return 0;
      end
      pos = newest[bkt];
      if (pos >= w) pos = w - 1;
      for (k = 0; k < w; k++) begin
        n = (pos + w - k) % w;
        if (way_tag[bkt][n] == tg) begin
          v = way_cnt[bkt][n];
          rsp = freq_of(v[1:0], v[3:2], v[5:4], v[7:6]);
          return 1;
        end
      end
      rsp = freq_of(0, 0, 0, 0);
      return 1;
    end
    ix = rq.context_req[15:0];
    if (rq.kind == KIND_UPDATE) begin
      nv = cnt_arr[ix][rq.symbol] + 16'd1;
      cnt_arr[ix][rq.symbol] = nv;
      if (nv == cfg.count_limit)
        for (k = 0; k < 4; k++) cnt_arr[ix][k] = cnt_arr[ix][k] >> 1;
      return 0;
    end
    rsp = freq_of(cnt_arr[ix][0], cnt_arr[ix][1], cnt_arr[ix][2], cnt_arr[ix][3]);
    return 1;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= CFG_AW'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_HASHED_MODE: cfg.hashed_mode = val[0];
      REG_ALPHA_SCALE: cfg.alpha_scale = val[9:0];
      REG_COUNT_LIMIT: cfg.count_limit = val[15:0];
      default:         cfg.ways_in_use = val[4:0];
    endcase
  endtask

  task automatic send_request(logic kind, logic [63:0] ctx, logic [1:0] sym);
    in_req_t rq;
    out_rsp_t e;
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
    end
    rq.kind = kind; rq.context_req = ctx; rq.symbol = sym;
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (in_stall_o);
    in_valid_i <= 1'b0;
    if (predict_counts(rq, e)) sb.note_request(e);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (IDLE_HOLD) @(posedge clk_i);
  endtask

  // random context biased toward a small working set so entries get reused
  function automatic logic [63:0] pick_context();
    case ($urandom_range(0, 3))
      0: return {$urandom(), $urandom()};
      1: return 64'($urandom_range(0, 15));
      default: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 28'h0,
                       4'($urandom_range(0, 7))} ^ 64'($urandom_range(0, 3) << 16);
    endcase
  endfunction

  task automatic random_phase(int unsigned n);
    logic [63:0] c;
    repeat (n) begin
      c = pick_context();
      if ($urandom_range(0, 2) == 0) send_request(KIND_LOOKUP, c, 2'($urandom()));
      else begin
        repeat ($urandom_range(1, 4)) send_request(KIND_UPDATE, c, 2'($urandom_range(0, 3)));
        send_request(KIND_LOOKUP, c, 2'($urandom()));
      end
    end
  endtask

  // result side: per result, stall a drawn number of valid cycles, check on accept
  always @(posedge clk_i) begin : rsp_side
    int unsigned wv;
    wv = out_wait;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
      results_seen++;
      wv = $urandom_range(0, 5);
    end else if (out_valid_o && (wv != 0)) begin
      wv = wv - 1;
    end
    out_wait    <= wv;
    out_stall_i <= (wv != 0);
  end

  // watchdog on cycles without any accepted transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int i, s;
    for (i = 0; i < CTX_N; i++) for (s = 0; s < 4; s++) cnt_arr[i][s] = '0;
    for (i = 0; i < NB; i++) begin
      newest[i] = '0;
      for (s = 0; s < NWAYS; s++) begin way_tag[i][s] = '0; way_cnt[i][s] = '0; end
    end
    cfg.hashed_mode = 1'b1; cfg.alpha_scale = 10'd1;
    cfg.count_limit = 16'hFFFF; cfg.ways_in_use = 5'd8;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: hash mode, cleared entries, extremes
    send_request(KIND_LOOKUP, 64'd0, 2'd0);
    send_request(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3);
    for (s = 0; s < 5; s++) send_request(KIND_UPDATE, 64'd5, 2'(s));
    send_request(KIND_UPDATE, 64'd5, 2'd0);
    send_request(KIND_UPDATE, 64'd5, 2'd0);
    send_request(KIND_LOOKUP, 64'd5, 2'd0);
    send_request(KIND_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3);
    send_request(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 2'd0);
    drain();
    write_reg(REG_ALPHA_SCALE, 32'd1023);
    write_reg(REG_WAYS_IN_USE, 32'd1);
    random_phase(100);
    drain();
    write_reg(REG_WAYS_IN_USE, 32'd16);
    write_reg(REG_ALPHA_SCALE, 32'd0);
    random_phase(70);
    drain();
    write_reg(REG_WAYS_IN_USE, 32'd0);
    write_reg(REG_ALPHA_SCALE, 32'd3);
    random_phase(70);
    drain();
    write_reg(REG_WAYS_IN_USE, 32'd31);
    random_phase(70);
    drain();
    // array mode, small limit, high context bits ignored
    write_reg(REG_HASHED_MODE, 32'd0);
    write_reg(REG_COUNT_LIMIT, 32'd2);
    write_reg(REG_ALPHA_SCALE, 32'd1023);
    send_request(KIND_UPDATE, 64'hFFFF_0000_0000_0007, 2'd1);
    send_request(KIND_UPDATE, 64'h0000_0000_0000_0007, 2'd1);
    send_request(KIND_LOOKUP, 64'hABCD_0000_0000_0007, 2'd0);
    random_phase(100);
    drain();
    write_reg(REG_COUNT_LIMIT, 32'd65535);
    write_reg(REG_ALPHA_SCALE, 32'd1);
    random_phase(80);
    drain();
    write_reg(REG_COUNT_LIMIT, 32'd0);
    write_reg(REG_ALPHA_SCALE, 32'd517);
    random_phase(80);
    drain();
    write_reg(REG_COUNT_LIMIT, 32'd5);
    random_phase(70);
    drain();
    // back to hash over state left by array mode
    write_reg(REG_HASHED_MODE, 32'd1);
    write_reg(REG_WAYS_IN_USE, 32'd4);
    random_phase(90);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
